// ===== src/ctrs_pkg.sv =====
// Shared types and constants for the count tree rank/select block.
`default_nettype none

package ctrs_pkg;

    localparam int TREE_DEPTH_DEF = 10;
    localparam int LEAF_MAX_DEF   = 64;

    // Leaf counters hold 0..64 at most.
    localparam int LEAF_W = 7;

    localparam int LEAF_INDEX_W = 10;
    localparam int DELTA_W      = 8;
    localparam int RANK_W       = 16;
    localparam int COUNT_W      = 17;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_SELECT = 1'b1;

    typedef struct packed {
        logic                      op;
        logic [LEAF_INDEX_W-1:0]   leaf_index;
        logic signed [DELTA_W-1:0] delta;
        logic [RANK_W-1:0]         rank;
    } cmd_t;

    typedef struct packed {
        logic [LEAF_INDEX_W-1:0] found_leaf;
        logic [COUNT_W-1:0]      count_below;
        logic [COUNT_W-1:0]      grand_total;
        logic                    fault;
    } result_t;

    // Port enables of the node and leaf memories.
    typedef struct packed {
        logic node_rd;
        logic node_wr;
        logic leaf_rd;
        logic leaf_wr;
    } mem_ctl_t;

endpackage

`default_nettype wire

// ===== src/ctrs_store.sv =====
// Node sum memory and leaf count memory, one write and one registered read port each.
`default_nettype none

module ctrs_store #(
    parameter int TREE_DEPTH = ctrs_pkg::TREE_DEPTH_DEF
) (
    input  wire                           clk,
    input  wire  ctrs_pkg::mem_ctl_t      ctl,
    input  wire  [TREE_DEPTH-1:0]         node_raddr,
    input  wire  [TREE_DEPTH-1:0]         node_waddr,
    input  wire  [2*(TREE_DEPTH+6)-1:0]   node_wdata,
    output logic [2*(TREE_DEPTH+6)-1:0]   node_rdata,
    input  wire  [TREE_DEPTH-1:0]         leaf_raddr,
    input  wire  [TREE_DEPTH-1:0]         leaf_waddr,
    input  wire  [ctrs_pkg::LEAF_W-1:0]   leaf_wdata,
    output logic [ctrs_pkg::LEAF_W-1:0]   leaf_rdata
);

    localparam int SUM_W      = TREE_DEPTH + 6;
    localparam int NUM_LEAVES = 2 ** TREE_DEPTH;
    localparam int NUM_NODES  = NUM_LEAVES - 1;

    // Each entry packs the left sum above the right sum.
    logic [2*SUM_W-1:0]          node_mem [NUM_NODES];
    logic [ctrs_pkg::LEAF_W-1:0] leaf_mem [NUM_LEAVES];

    logic [2*SUM_W-1:0]          node_rdata_reg;
    logic [ctrs_pkg::LEAF_W-1:0] leaf_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.node_wr)
        begin
            node_mem[node_waddr] <= node_wdata;
        end
        if (ctl.node_rd)
        begin
            node_rdata_reg <= node_mem[node_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.leaf_wr)
        begin
            leaf_mem[leaf_waddr] <= leaf_wdata;
        end
        if (ctl.leaf_rd)
        begin
            leaf_rdata_reg <= leaf_mem[leaf_raddr];
        end
    end

    assign node_rdata = node_rdata_reg;
    assign leaf_rdata = leaf_rdata_reg;

endmodule

`default_nettype wire

// ===== src/count_tree_rank_select.sv =====
// The result strobe is registered from the walk state of the last tree level; a refused
// update reports from the root level, where its leaf bounds check fails.
// A new transaction is taken only once the previous one has reported and busy is low:
// each tree level needs its own node read on the node memory port.
// Reset: a clearing pass over every leaf address zeroes both memories with busy high;
// results go out on a strobe that cannot be stalled.
`default_nettype none

module count_tree_rank_select #(
    parameter int TREE_DEPTH = ctrs_pkg::TREE_DEPTH_DEF,
    parameter int LEAF_MAX   = ctrs_pkg::LEAF_MAX_DEF
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                start,
    output logic               busy,
    input  wire ctrs_pkg::cmd_t cmd,
    output logic               done,
    output ctrs_pkg::result_t  result
);

    localparam int SUM_W   = TREE_DEPTH + 6;
    localparam int BELOW_W = TREE_DEPTH + 7;
    localparam int CMP_W   = BELOW_W + ctrs_pkg::RANK_W;
    localparam int LVL_W   = $clog2(TREE_DEPTH + 1);
    localparam int LEXT_W  = TREE_DEPTH + ctrs_pkg::LEAF_INDEX_W;
    localparam int BEXT_W  = BELOW_W + ctrs_pkg::COUNT_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CLEAR = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;

    // Control state
    logic [1:0]            state_reg, state_next;
    logic [LVL_W-1:0]      lvl_reg, lvl_next;
    logic [TREE_DEPTH-1:0] clr_reg, clr_next;
    logic [BELOW_W-1:0]    total_reg, total_next;
    logic                  done_reg, done_next;

    // Transaction payload
    logic                                    op_reg, op_next;
    logic [TREE_DEPTH-1:0]                   path_reg, path_next;
    logic signed [ctrs_pkg::DELTA_W-1:0]     delta_reg, delta_next;
    logic [ctrs_pkg::RANK_W-1:0]             rank_reg, rank_next;
    logic [TREE_DEPTH-1:0]                   node_reg, node_next;
    logic [BELOW_W-1:0]                      below_reg, below_next;
    logic [TREE_DEPTH-1:0]                   found_reg, found_next;
    ctrs_pkg::result_t                       result_reg, result_next;

    // Memory interface
    ctrs_pkg::mem_ctl_t          mem_ctl;
    logic [TREE_DEPTH-1:0]       node_raddr, node_waddr;
    logic [2*SUM_W-1:0]          node_wdata, node_rdata;
    logic [TREE_DEPTH-1:0]       leaf_raddr, leaf_waddr;
    logic [ctrs_pkg::LEAF_W-1:0] leaf_wdata, leaf_rdata;

    // Datapath
    logic                  accept;
    logic                  walking;
    logic                  is_update;
    logic                  lvl_first;
    logic                  lvl_last;
    logic [SUM_W-1:0]      left_sum, right_sum, d_sum;
    logic [BELOW_W-1:0]    below_plus;
    logic                  go_right_sel;
    logic                  dir;
    logic [TREE_DEPTH:0]   child;
    logic [TREE_DEPTH:0]   path_wide;
    logic [TREE_DEPTH:0]   found_wide;
    logic signed [8:0]     cnt_sum;
    logic                  fault_now;
    logic                  abort;
    logic                  finish;
    logic                  leaf_commit;
    logic [BELOW_W-1:0]    total_cur;
    logic [LEXT_W-1:0]     leaf_ext;
    logic [LEXT_W-1:0]     found_ext;
    logic [BEXT_W-1:0]     below_ext;
    logic [BEXT_W-1:0]     total_ext;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign walking   = (state_reg == ST_WALK);
    assign is_update = (op_reg == ctrs_pkg::OP_UPDATE);
    assign lvl_first = (lvl_reg == '0);
    assign lvl_last  = (lvl_reg == LVL_W'(TREE_DEPTH - 1));

    assign left_sum  = node_rdata[2*SUM_W-1:SUM_W];
    assign right_sum = node_rdata[SUM_W-1:0];
    assign d_sum     = SUM_W'(delta_reg);

    // Select descent: go right when below + left <= rank, or the left side is empty.
    assign below_plus   = below_reg + BELOW_W'(left_sum);
    assign go_right_sel = (CMP_W'(below_plus) <= CMP_W'(rank_reg)) || (left_sum == '0);
    assign dir          = is_update ? path_reg[TREE_DEPTH-1] : go_right_sel;

    assign child      = {node_reg, 1'b0} + (TREE_DEPTH + 1)'(1) + (TREE_DEPTH + 1)'(dir);
    assign path_wide  = {path_reg, 1'b0};
    assign found_wide = {found_reg, dir};

    // Leaf bounds check on the leaf read that arrives with the root node.
    assign cnt_sum   = $signed({2'b00, leaf_rdata}) + $signed({delta_reg[7], delta_reg});
    assign fault_now = cnt_sum[8] || (cnt_sum[7:0] > 8'(LEAF_MAX));

    assign abort       = walking && is_update && lvl_first && fault_now;
    assign finish      = walking && (lvl_last || abort);
    assign leaf_commit = walking && is_update && lvl_first && !fault_now;

    assign total_cur = leaf_commit ? (total_reg + BELOW_W'(delta_reg)) : total_reg;

    assign leaf_ext  = LEXT_W'(cmd.leaf_index);
    assign found_ext = LEXT_W'(found_wide[TREE_DEPTH-1:0]);
    assign below_ext = BEXT_W'(dir ? below_plus : below_reg);
    assign total_ext = BEXT_W'(total_cur);

    always_comb
    begin
        mem_ctl.node_rd = accept || (walking && !finish);
        mem_ctl.node_wr = ((state_reg == ST_CLEAR) && (clr_reg != '1))
                          || (walking && is_update && !abort);
        mem_ctl.leaf_rd = accept;
        mem_ctl.leaf_wr = (state_reg == ST_CLEAR) || leaf_commit;

        node_raddr = accept ? '0 : child[TREE_DEPTH-1:0];
        leaf_raddr = leaf_ext[TREE_DEPTH-1:0];

        if (state_reg == ST_CLEAR)
        begin
            node_waddr = clr_reg;
            node_wdata = '0;
            leaf_waddr = clr_reg;
            leaf_wdata = '0;
        end
        else
        begin
            node_waddr = node_reg;
            node_wdata = dir ? {left_sum, right_sum + d_sum} : {left_sum + d_sum, right_sum};
            leaf_waddr = path_reg;
            leaf_wdata = cnt_sum[ctrs_pkg::LEAF_W-1:0];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        lvl_next    = lvl_reg;
        clr_next    = clr_reg;
        total_next  = total_reg;
        done_next   = 1'b0;
        op_next     = op_reg;
        path_next   = path_reg;
        delta_next  = delta_reg;
        rank_next   = rank_reg;
        node_next   = node_reg;
        below_next  = below_reg;
        found_next  = found_reg;
        result_next = result_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_WALK;
                    lvl_next   = '0;
                    op_next    = cmd.op;
                    path_next  = leaf_ext[TREE_DEPTH-1:0];
                    delta_next = cmd.delta;
                    rank_next  = cmd.rank;
                    node_next  = '0;
                    below_next = '0;
                    found_next = '0;
                end
            end
            ST_WALK:
            begin
                total_next = total_cur;
                lvl_next   = lvl_reg + 1'b1;
                path_next  = path_wide[TREE_DEPTH-1:0];
                node_next  = child[TREE_DEPTH-1:0];
                found_next = found_wide[TREE_DEPTH-1:0];
                if (dir)
                begin
                    below_next = below_plus;
                end
                if (finish)
                begin
                    state_next              = ST_IDLE;
                    done_next               = 1'b1;
                    result_next.grand_total = total_ext[ctrs_pkg::COUNT_W-1:0];
                    result_next.fault       = abort;
                    if (is_update)
                    begin
                        result_next.found_leaf  = '0;
                        result_next.count_below = '0;
                    end
                    else
                    begin
                        result_next.found_leaf  = found_ext[ctrs_pkg::LEAF_INDEX_W-1:0];
                        result_next.count_below = below_ext[ctrs_pkg::COUNT_W-1:0];
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            lvl_reg   <= '0;
            clr_reg   <= '0;
            total_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lvl_reg   <= lvl_next;
            clr_reg   <= clr_next;
            total_reg <= total_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        path_reg   <= path_next;
        delta_reg  <= delta_next;
        rank_reg   <= rank_next;
        node_reg   <= node_next;
        below_reg  <= below_next;
        found_reg  <= found_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    ctrs_store #(
        .TREE_DEPTH (TREE_DEPTH)
    ) u_store (
        .clk        (clk),
        .ctl        (mem_ctl),
        .node_raddr (node_raddr),
        .node_waddr (node_waddr),
        .node_wdata (node_wdata),
        .node_rdata (node_rdata),
        .leaf_raddr (leaf_raddr),
        .leaf_waddr (leaf_waddr),
        .leaf_wdata (leaf_wdata),
        .leaf_rdata (leaf_rdata)
    );

`ifndef SYNTHESIS
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_last_level_reports: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && lvl_last) |=> done)
        else $error("last tree level processed without a result");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while a transaction is still in the tree");

    a_fault_update_only: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.fault) |-> (result.found_leaf == '0 && result.count_below == '0))
        else $error("refused update reported select fields");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for count_tree_rank_select: directed table, then random traffic.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = ctrs_pkg::TREE_DEPTH_DEF;
    localparam int LEAVES      = 1 << DEPTH;
    localparam int NODES       = LEAVES - 1;
    localparam int CAP         = ctrs_pkg::LEAF_MAX_DEF;
    localparam int SETTLE      = DEPTH + 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDX_W       = ctrs_pkg::LEAF_INDEX_W;
    localparam int CNT_W       = ctrs_pkg::COUNT_W;
    localparam int DLT_W       = ctrs_pkg::DELTA_W;
    localparam int RNK_W       = ctrs_pkg::RANK_W;

    typedef struct {
        ctrs_pkg::cmd_t    c;
        bit                fixed;
        ctrs_pkg::result_t want;
    } row_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              done;
    ctrs_pkg::cmd_t    cmd;
    ctrs_pkg::result_t result;

    // Shadow copy of the tree
    int leaf_cnt [LEAVES];
    int left_sum [NODES];
    int right_sum[NODES];

    ctrs_pkg::result_t pending_results[$];
    ctrs_pkg::result_t oldest;
    row_t              plan[$];
    int                errors;
    int                cycles;
    int                quiet_left;

    count_tree_rank_select #(
        .TREE_DEPTH(DEPTH),
        .LEAF_MAX  (CAP)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .result(result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int tree_total();
        return left_sum[0] + right_sum[0];
    endfunction

    // Apply one transaction to the shadow tree and return what the block should report.
    function automatic ctrs_pkg::result_t apply_to_tree(ctrs_pkg::cmd_t c);
        ctrs_pkg::result_t r;
        int      leaf;
        int      d;
        int      nxt;
        int      node;
        int      below;
        int      l;
        bit      go_right;
        r = '0;
        if (c.op == ctrs_pkg::OP_UPDATE)
        begin
            leaf = int'(c.leaf_index) & (LEAVES - 1);
            d    = $signed(c.delta);
            nxt  = leaf_cnt[leaf] + d;
            if (nxt < 0 || nxt > CAP)
                r.fault = 1'b1;
            else
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    node = ((1 << i) - 1) + (leaf >> (DEPTH - i));
                    if ((leaf >> (DEPTH - i - 1)) & 1)
                        right_sum[node] += d;
                    else
                        left_sum[node] += d;
                end
                leaf_cnt[leaf] = nxt;
            end
        end
        else
        begin
            node  = 0;
            below = 0;
            for (int i = 0; i < DEPTH; i++)
            begin
                l        = left_sum[node];
                go_right = (below + l <= int'(c.rank)) || (l == 0);
                if (go_right)
                    below += l;
                node = 2 * node + 1 + int'(go_right);
            end
            r.found_leaf  = IDX_W'(node - NODES);
            r.count_below = CNT_W'(below);
        end
        r.grand_total = CNT_W'(tree_total());
        return r;
    endfunction

    function automatic ctrs_pkg::cmd_t make_cmd(logic op, int leaf, int delta, int rank);
        ctrs_pkg::cmd_t c;
        c.op         = op;
        c.leaf_index = IDX_W'(leaf);
        c.delta      = DLT_W'(delta);
        c.rank       = RNK_W'(rank);
        return c;
    endfunction

    function automatic ctrs_pkg::result_t make_res(int found, int below, int total, bit fault);
        ctrs_pkg::result_t r;
        r.found_leaf  = IDX_W'(found);
        r.count_below = CNT_W'(below);
        r.grand_total = CNT_W'(total);
        r.fault       = fault;
        return r;
    endfunction

    function automatic void add_row(ctrs_pkg::cmd_t c, bit fixed, ctrs_pkg::result_t want);
        row_t row;
        row.c     = c;
        row.fixed = fixed;
        row.want  = want;
        plan.insert(plan.size(), row);
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones, and idle-free stretches.
    function automatic int idle_cycles();
        int r;
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            quiet_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic ctrs_pkg::cmd_t random_update();
        int leaf;
        int delta;
        case ($urandom_range(0, 3))
            0:       leaf = $urandom_range(0, 15);
            1:       leaf = $urandom_range(LEAVES - 16, LEAVES - 1);
            default: leaf = $urandom_range(0, LEAVES - 1);
        endcase
        // Mostly legal deltas (uniform target count), some raw 8-bit values
        if ($urandom_range(0, 4) == 0)
            delta = $urandom_range(0, 255);
        else
            delta = $urandom_range(0, CAP) - leaf_cnt[leaf];
        return make_cmd(ctrs_pkg::OP_UPDATE, leaf, delta, $urandom_range(0, 65535));
    endfunction

    function automatic ctrs_pkg::cmd_t random_select();
        int total;
        int rank;
        total = tree_total();
        if (total == 0 || $urandom_range(0, 4) == 0)
            rank = $urandom_range(0, 65535);
        else
            rank = $urandom_range(0, (total > 65535) ? 65535 : total);
        return make_cmd(ctrs_pkg::OP_SELECT, $urandom_range(0, LEAVES - 1),
                        $urandom_range(0, 255), rank);
    endfunction

    function automatic ctrs_pkg::cmd_t random_item();
        if ($urandom_range(0, 9) < 6)
            return random_update();
        return random_select();
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
        errors++;
    endtask

    // Present one transaction, hold it until accepted, then record its expected result.
    task automatic send(ctrs_pkg::cmd_t c, bit fixed, ctrs_pkg::result_t want);
        int                gap;
        ctrs_pkg::result_t predicted;
        gap = idle_cycles();
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            cmd   <= ctrs_pkg::cmd_t'({$urandom, $urandom});
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        predicted = apply_to_tree(c);
        pending_results.insert(pending_results.size(), fixed ? want : predicted);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing pending", 1, 0);
            else
            begin
                oldest = pending_results.pop_front();
                if (result.found_leaf !== oldest.found_leaf)
                    report_mismatch("found_leaf", result.found_leaf, oldest.found_leaf);
                if (result.count_below !== oldest.count_below)
                    report_mismatch("count_below", result.count_below, oldest.count_below);
                if (result.grand_total !== oldest.grand_total)
                    report_mismatch("grand_total", result.grand_total, oldest.grand_total);
                if (result.fault !== oldest.fault)
                    report_mismatch("fault", result.fault, oldest.fault);
            end
        end
    end

    initial
    begin
        errors     = 0;
        cycles     = 0;
        quiet_left = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        cmd        = '0;

        // empty tree, refusals at both bounds, zero delta, extreme ranks
        add_row(make_cmd(ctrs_pkg::OP_SELECT, 0, 0, 0), 1, make_res(LEAVES - 1, 0, 0, 0));
        add_row(make_cmd(ctrs_pkg::OP_UPDATE, 0, -1, 0), 1, make_res(0, 0, 0, 1));
        add_row(make_cmd(ctrs_pkg::OP_UPDATE, 0, CAP, 0), 1, make_res(0, 0, 64, 0));
        add_row(make_cmd(ctrs_pkg::OP_UPDATE, 0, 1, 0), 1, make_res(0, 0, 64, 1));
        add_row(make_cmd(ctrs_pkg::OP_UPDATE, LEAVES - 1, CAP, 0), 1, make_res(0, 0, 128, 0));
        add_row(make_cmd(ctrs_pkg::OP_UPDATE, 5, 0, 0), 1, make_res(0, 0, 128, 0));
        add_row(make_cmd(ctrs_pkg::OP_UPDATE, 5, -128, 0), 1, make_res(0, 0, 128, 1));
        add_row(make_cmd(ctrs_pkg::OP_UPDATE, 5, 127, 0), 1, make_res(0, 0, 128, 1));
        add_row(make_cmd(ctrs_pkg::OP_SELECT, 0, 0, 0), 1, make_res(0, 0, 128, 0));
        add_row(make_cmd(ctrs_pkg::OP_SELECT, 0, 0, 63), 1, make_res(0, 0, 128, 0));
        add_row(make_cmd(ctrs_pkg::OP_SELECT, 0, 0, 64), 1, make_res(LEAVES - 1, 64, 128, 0));
        add_row(make_cmd(ctrs_pkg::OP_SELECT, 0, 0, 65535), 0, '0);
        add_row(make_cmd(ctrs_pkg::OP_UPDATE, 512, 10, 65535), 0, '0);
        add_row(make_cmd(ctrs_pkg::OP_SELECT, LEAVES - 1, -1, 100), 0, '0);
        add_row(make_cmd(ctrs_pkg::OP_UPDATE, LEAVES - 1, -CAP, 0), 0, '0);
        add_row(make_cmd(ctrs_pkg::OP_UPDATE, 1, 1, 0), 0, '0);
        add_row(make_cmd(ctrs_pkg::OP_SELECT, 0, 0, 64), 0, '0);
        add_row(make_cmd(ctrs_pkg::OP_UPDATE, 0, -CAP, 0), 0, '0);
        add_row(make_cmd(ctrs_pkg::OP_SELECT, 0, 0, 0), 0, '0);
        add_row(make_cmd(ctrs_pkg::OP_UPDATE, 512, -10, 0), 0, '0);
        add_row(make_cmd(ctrs_pkg::OP_UPDATE, 1, -1, 0), 0, '0);
        add_row(make_cmd(ctrs_pkg::OP_SELECT, 0, 0, 65535), 1, make_res(LEAVES - 1, 0, 0, 0));

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
            send(plan[i].c, plan[i].fixed, plan[i].want);

        // sparse, mixed traffic
        repeat (220)
            send(random_item(), 0, '0);

        // fill every leaf to the cap, probing by rank along the way
        for (int leaf = 0; leaf < LEAVES; leaf++)
        begin
            send(make_cmd(ctrs_pkg::OP_UPDATE, leaf, CAP - leaf_cnt[leaf],
                          $urandom_range(0, 65535)), 0, '0);
            if ($urandom_range(0, 5) == 0)
                send(random_select(), 0, '0);
        end
        send(make_cmd(ctrs_pkg::OP_SELECT, 0, 0, 65535), 0, '0);
        send(make_cmd(ctrs_pkg::OP_UPDATE, 300, 1, 0), 0, '0);

        // random traffic from a full tree
        repeat (160)
            send(random_item(), 0, '0);

        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
